// File: rtl/core/adrd_pkg.sv
package adrd_pkg;

   // Largest frame the position counter covers
   localparam logic [20:0] MAX_PIXELS = 21'h100000;

   // Header mark byte ('B')
   localparam logic [7:0] RECORD_MARK = 8'h42;

   // Register reset values
   localparam logic [20:0] FRAME_PIXELS_RESET = 21'd64000;
   localparam logic [15:0] FRAME_COUNT_RESET  = 16'd1;

   // Configuration register indexes
   typedef enum logic [0:0] {
      CSR_FRAME_PIXELS = 1'b0,
      CSR_FRAME_COUNT  = 1'b1
   } csr_index_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD_MARK = 2'd1,
      ST_BAD_ZERO = 2'd2,
      ST_CLIPPED  = 2'd3
   } status_type;

   // Record parser phases
   typedef enum logic [3:0] {
      PH_MARK   = 4'd0,
      PH_ZERO   = 4'd1,
      PH_TYPE   = 4'd2,
      PH_PAD    = 4'd3,
      PH_RAW    = 4'd4,
      PH_KEY    = 4'd5,
      PH_RUNCNT = 4'd6,
      PH_RUNVAL = 4'd7,
      PH_DUMP   = 4'd8,
      PH_LONGLO = 4'd9,
      PH_LONGHI = 4'd10,
      PH_TAIL   = 4'd11
   } phase_type;

endpackage

// File: rtl/core/anim_delta_record_decoder_top.sv
// A result is registered and shows on rsp_* in the cycle after its item is accepted.
// Throughput: one item per cycle; req_ready drops only while a result
// waits in the output register and rsp_ready is low.
// Reset (synchronous, active high): parser back to the first header byte,
// position and frame index zero, registers to 64000 pixels and 1 frame.
module anim_delta_record_decoder_top (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [7:0]  req_data_byte,
   input  logic        req_record_last,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_has_write,
   output logic [19:0] rsp_pixel_index,
   output logic [13:0] rsp_span_length,
   output logic [7:0]  rsp_pixel_value,
   output logic        rsp_frame_done,
   output logic [15:0] rsp_frame_number,
   output logic        rsp_all_done,
   output logic [1:0]  rsp_status,
   // configuration port
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [20:0] csr_wdata
);

   // configuration
   logic [20:0] frame_pixels_ff;
   logic [15:0] frame_count_ff;

   // parser state
   adrd_pkg::phase_type phase_ff, phase_in;
   logic        raw_ff, raw_in;
   logic [14:0] pend_ff, pend_in;
   logic [7:0]  low_ff, low_in;
   logic [20:0] pos_ff, pos_in;
   logic [15:0] fidx_ff, fidx_in;
   logic        halted_ff, halted_in;
   logic        finished_ff, finished_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        write_ff, write_in;
   logic [19:0] index_ff, index_in;
   logic [13:0] len_ff, len_in;
   logic [7:0]  value_ff, value_in;
   logic        done_ff, done_in;
   logic [15:0] fnum_ff;
   logic        all_ff, all_in;
   adrd_pkg::status_type status_ff, status_in;

   // step scratch
   logic        accept;
   logic        take;
   logic        res_any;
   logic        adv;
   logic [20:0] fp;
   logic [20:0] avail;
   logic        skip_en;
   logic [14:0] skip_n;
   logic        span_en;
   logic [14:0] span_len;
   logic [7:0]  span_val;
   logic [14:0] cut;
   logic [15:0] key_word;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign take      = accept && !halted_ff && !finished_ff;
   assign csr_ready = 1'b1;

   // effective frame size, clamped to 1..MAX_PIXELS
   always_comb begin
      if (frame_pixels_ff == 21'd0) begin
         fp = 21'd1;
      end else if (frame_pixels_ff > adrd_pkg::MAX_PIXELS) begin
         fp = adrd_pkg::MAX_PIXELS;
      end else begin
         fp = frame_pixels_ff;
      end
      avail = (pos_ff >= fp) ? 21'd0 : fp - pos_ff;
   end

   // one parse step per accepted item while not halted or finished
   always_comb begin
      phase_in    = phase_ff;
      raw_in      = raw_ff;
      pend_in     = pend_ff;
      low_in      = low_ff;
      pos_in      = pos_ff;
      fidx_in     = fidx_ff;
      halted_in   = halted_ff;
      finished_in = finished_ff;
      res_any     = 1'b0;
      adv         = 1'b0;
      write_in    = 1'b0;
      index_in    = 20'd0;
      len_in      = 14'd0;
      value_in    = 8'd0;
      done_in     = 1'b0;
      all_in      = 1'b0;
      status_in   = adrd_pkg::ST_OK;
      skip_en     = 1'b0;
      skip_n      = 15'd0;
      span_en     = 1'b0;
      span_len    = 15'd0;
      span_val    = req_data_byte;
      cut         = 15'd0;
      key_word    = {req_data_byte, low_ff};

      if (take) begin
         if (req_cmd) begin
            adv = 1'b1;
         end else begin
            unique case (phase_ff)
               adrd_pkg::PH_MARK: begin
                  if (req_data_byte != adrd_pkg::RECORD_MARK) begin
                     halted_in = 1'b1;
                     res_any   = 1'b1;
                     status_in = adrd_pkg::ST_BAD_MARK;
                  end else begin
                     raw_in   = 1'b0;
                     phase_in = adrd_pkg::PH_ZERO;
                  end
               end
               adrd_pkg::PH_ZERO: begin
                  if (req_data_byte != 8'd0) begin
                     halted_in = 1'b1;
                     res_any   = 1'b1;
                     status_in = adrd_pkg::ST_BAD_ZERO;
                  end else begin
                     phase_in = adrd_pkg::PH_TYPE;
                  end
               end
               adrd_pkg::PH_TYPE: begin
                  raw_in   = (req_data_byte == 8'd0);
                  phase_in = adrd_pkg::PH_PAD;
               end
               adrd_pkg::PH_PAD: begin
                  phase_in = raw_ff ? adrd_pkg::PH_RAW : adrd_pkg::PH_KEY;
               end
               adrd_pkg::PH_RAW: begin
                  span_en  = 1'b1;
                  span_len = 15'd1;
               end
               adrd_pkg::PH_KEY: begin
                  if (req_data_byte == 8'd0) begin
                     phase_in = adrd_pkg::PH_RUNCNT;
                  end else if (!req_data_byte[7]) begin
                     pend_in  = {8'd0, req_data_byte[6:0]};
                     phase_in = adrd_pkg::PH_DUMP;
                  end else if (req_data_byte[6:0] == 7'd0) begin
                     phase_in = adrd_pkg::PH_LONGLO;
                  end else begin
                     skip_en = 1'b1;
                     skip_n  = {8'd0, req_data_byte[6:0]};
                  end
               end
               adrd_pkg::PH_RUNCNT: begin
                  pend_in  = {7'd0, req_data_byte};
                  phase_in = adrd_pkg::PH_RUNVAL;
               end
               adrd_pkg::PH_RUNVAL: begin
                  span_en  = 1'b1;
                  span_len = pend_ff;
                  pend_in  = 15'd0;
                  phase_in = adrd_pkg::PH_KEY;
               end
               adrd_pkg::PH_DUMP: begin
                  span_en  = 1'b1;
                  span_len = 15'd1;
                  pend_in  = pend_ff - 15'd1;
                  if (pend_in == 15'd0) begin
                     phase_in = adrd_pkg::PH_KEY;
                  end
               end
               adrd_pkg::PH_LONGLO: begin
                  low_in   = req_data_byte;
                  phase_in = adrd_pkg::PH_LONGHI;
               end
               adrd_pkg::PH_LONGHI: begin
                  phase_in = adrd_pkg::PH_KEY;
                  if (key_word == 16'd0) begin
                     phase_in = adrd_pkg::PH_TAIL;
                  end else if (!key_word[15]) begin
                     skip_en = 1'b1;
                     skip_n  = key_word[14:0];
                  end else begin
                     pend_in = {1'b0, key_word[13:0]};
                     if (key_word[14]) begin
                        phase_in = adrd_pkg::PH_RUNVAL;
                     end else if (key_word[13:0] != 14'd0) begin
                        phase_in = adrd_pkg::PH_DUMP;
                     end
                  end
               end
               default: begin
                  // end key seen: bytes up to record end are dropped
               end
            endcase

            // skip, stopping at the frame end
            if (skip_en) begin
               pos_in = ({6'd0, skip_n} > avail) ? fp : pos_ff + {6'd0, skip_n};
            end

            // span, clipped to what is left of the frame
            if (span_en && span_len != 15'd0) begin
               res_any = 1'b1;
               cut = ({6'd0, span_len} > avail) ? avail[14:0] : span_len;
               if (cut != span_len) begin
                  status_in = adrd_pkg::ST_CLIPPED;
               end
               if (cut != 15'd0) begin
                  write_in = 1'b1;
                  index_in = pos_ff[19:0];
                  len_in   = cut[13:0];
                  value_in = span_val;
               end
               pos_in = pos_ff + {6'd0, cut};
            end

            // record end: raw records advance only on a full frame
            if (!halted_in && req_record_last) begin
               if (raw_in && (phase_in == adrd_pkg::PH_RAW || phase_in == adrd_pkg::PH_PAD)
                   && pos_in < fp) begin
                  phase_in = adrd_pkg::PH_MARK;
               end else begin
                  adv = 1'b1;
               end
            end
         end

         // frame advance
         if (adv) begin
            res_any  = 1'b1;
            done_in  = 1'b1;
            fidx_in  = fidx_ff + 16'd1;
            pos_in   = 21'd0;
            phase_in = adrd_pkg::PH_MARK;
            raw_in   = 1'b0;
            pend_in  = 15'd0;
            low_in   = 8'd0;
            if (fidx_in >= frame_count_ff) begin
               finished_in = 1'b1;
               all_in      = 1'b1;
            end
         end
      end

      // output register valid
      if (accept) begin
         rsp_valid_in = res_any;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_pixels_ff <= adrd_pkg::FRAME_PIXELS_RESET;
         frame_count_ff  <= adrd_pkg::FRAME_COUNT_RESET;
         phase_ff        <= adrd_pkg::PH_MARK;
         raw_ff          <= 1'b0;
         pend_ff         <= 15'd0;
         low_ff          <= 8'd0;
         pos_ff          <= 21'd0;
         fidx_ff         <= 16'd0;
         halted_ff       <= 1'b0;
         finished_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               adrd_pkg::CSR_FRAME_PIXELS: frame_pixels_ff <= csr_wdata;
               adrd_pkg::CSR_FRAME_COUNT:  frame_count_ff  <= csr_wdata[15:0];
               default: begin
               end
            endcase
         end
         phase_ff     <= phase_in;
         raw_ff       <= raw_in;
         pend_ff      <= pend_in;
         low_ff       <= low_in;
         pos_ff       <= pos_in;
         fidx_ff      <= fidx_in;
         halted_ff    <= halted_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (take && res_any) begin
         write_ff  <= write_in;
         index_ff  <= index_in;
         len_ff    <= len_in;
         value_ff  <= value_in;
         done_ff   <= done_in;
         fnum_ff   <= fidx_ff;
         all_ff    <= all_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_has_write    = write_ff;
   assign rsp_pixel_index  = index_ff;
   assign rsp_span_length  = len_ff;
   assign rsp_pixel_value  = value_ff;
   assign rsp_frame_done   = done_ff;
   assign rsp_frame_number = fnum_ff;
   assign rsp_all_done     = all_ff;
   assign rsp_status       = status_ff;

`ifndef ASSERT_OFF
   // a write always carries at least one pixel
   a_write_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && write_ff |-> len_ff != 14'd0)
      else $error("write item with zero span length");

   // header errors carry no write and no frame end
   a_err_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == adrd_pkg::ST_BAD_MARK ||
                       status_ff == adrd_pkg::ST_BAD_ZERO)
      |-> !write_ff && !done_ff)
      else $error("header error item carries other results");

   // halt holds until reset
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt cleared without reset");

   // last frame end is also a frame end
   a_all_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && all_ff |-> done_ff)
      else $error("all_done without frame_done");

   // position never passes the frame
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= adrd_pkg::MAX_PIXELS)
      else $error("position beyond largest frame");
`endif

endmodule
